// ----- hw/rtl/mbpg_pkg.sv -----
// Shared types and constants for the MSB-first bit packer with gamma encoder.
`timescale 1ns / 1ps
`default_nettype none

package mbpg_pkg;

   // Request codes
   localparam logic [1:0] REQ_RAW   = 2'd0;
   localparam logic [1:0] REQ_GAMMA = 2'd1;
   localparam logic [1:0] REQ_FLUSH = 2'd2;

   localparam int BYTE_BITS = 8;
   localparam int VALUE_BITS = 32;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [VALUE_BITS-1:0] value;
      logic [5:0]            bit_count;
   } req_type_t_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 last;
   } rsp_payload_type;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ALIGN = 4'b0010,
      ST_EMIT  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/msb_bit_packer_gamma_encoder.sv -----
// Top level: bit-serial MSB-first packer with raw, Elias gamma and flush requests.
`timescale 1ns / 1ps
`default_nettype none

// Packs bits into bytes, most significant bit first, one bit per clock through a
// WORD_BITS-wide shift register. A request is taken only while the block is idle.
// A raw write of n bits (n = min(bit_count, WORD_BITS), n > 0) first shifts the unused
// high bits out, then packs the n bits. A gamma write of a value of bit length L first
// shifts to find the leading one, then packs the zero prefix and the value bits. A flush
// sends the pending partial byte. Raw writes of zero bits, gamma writes of zero, flushes
// with nothing pending and request type 3 produce nothing. Each completed byte goes to a
// one-entry output register; packing pauses only when a byte completes while that
// register still holds a byte not yet taken. The final byte of each request carries
// last.
module msb_bit_packer_gamma_encoder #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire mbpg_pkg::req_type_t_type      req_payload,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      mbpg_pkg::rsp_payload_type     rsp_payload
);

   localparam int LW = $clog2(WORD_BITS + 1);
   localparam int BW = $clog2(2 * WORD_BITS);
   localparam logic [LW-1:0] WORD_LEN = LW'(WORD_BITS);

   mbpg_pkg::state_type state_ff, state_in;

   logic [WORD_BITS-1:0] sr_ff, sr_in;
   logic [LW-1:0]        cnt_ff, cnt_in;
   logic [LW-1:0]        data_len_ff, data_len_in;
   logic [BW-1:0]        bits_left_ff, bits_left_in;
   logic                 gamma_ff, gamma_in;
   logic [7:0]           pend_ff, pend_in;
   logic [3:0]           free_ff, free_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mbpg_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic                 slot_free;
   logic                 zero_phase;
   logic                 emit_bit;
   logic                 complete;
   logic [2:0]           bit_pos;
   logic [7:0]           pend_bit;
   logic [LW-1:0]        raw_len;
   logic [WORD_BITS-1:0] word_val;

   assign req_ready   = (state_ff == mbpg_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign word_val  = req_payload.value[WORD_BITS-1:0];
   assign raw_len   = ({1'b0, req_payload.bit_count} > 7'(WORD_BITS)) ?
                      WORD_LEN : LW'(req_payload.bit_count);

   // Bit to pack: zero prefix of a gamma code, else the shift register's top bit
   assign zero_phase = bits_left_ff > BW'(data_len_ff);
   assign emit_bit   = zero_phase ? 1'b0 : sr_ff[WORD_BITS-1];
   assign complete   = (free_ff == 4'd1);
   assign bit_pos    = 3'(free_ff - 4'd1);

   always_comb begin
      pend_bit          = pend_ff;
      pend_bit[bit_pos] = emit_bit;
   end

   // Sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      sr_in        = sr_ff;
      cnt_in       = cnt_ff;
      data_len_in  = data_len_ff;
      bits_left_in = bits_left_ff;
      gamma_in     = gamma_ff;
      pend_in      = pend_ff;
      free_in      = free_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         mbpg_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_payload.req_type)
                  mbpg_pkg::REQ_RAW: begin
                     if (raw_len != '0) begin
                        sr_in       = word_val;
                        cnt_in      = WORD_LEN - raw_len;
                        data_len_in = raw_len;
                        gamma_in    = 1'b0;
                        state_in    = mbpg_pkg::ST_ALIGN;
                     end
                  end
                  mbpg_pkg::REQ_GAMMA: begin
                     if (word_val != '0) begin
                        sr_in    = word_val;
                        cnt_in   = WORD_LEN;
                        gamma_in = 1'b1;
                        state_in = mbpg_pkg::ST_ALIGN;
                     end
                  end
                  mbpg_pkg::REQ_FLUSH: begin
                     if (free_ff != 4'd8) begin
                        state_in = mbpg_pkg::ST_FLUSH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         mbpg_pkg::ST_ALIGN: begin
            // Gamma: shift to the leading one, counting the bit length down.
            // Raw: shift the bits above the count out.
            if (gamma_ff) begin
               if (sr_ff[WORD_BITS-1]) begin
                  data_len_in  = cnt_ff;
                  bits_left_in = BW'({cnt_ff, 1'b0} - (LW+1)'(1));
                  state_in     = mbpg_pkg::ST_EMIT;
               end else begin
                  sr_in  = {sr_ff[WORD_BITS-2:0], 1'b0};
                  cnt_in = cnt_ff - LW'(1);
               end
            end else begin
               if (cnt_ff == '0) begin
                  bits_left_in = BW'(data_len_ff);
                  state_in     = mbpg_pkg::ST_EMIT;
               end else begin
                  sr_in  = {sr_ff[WORD_BITS-2:0], 1'b0};
                  cnt_in = cnt_ff - LW'(1);
               end
            end
         end
         mbpg_pkg::ST_EMIT: begin
            if (!complete || slot_free) begin
               if (!zero_phase) begin
                  sr_in = {sr_ff[WORD_BITS-2:0], 1'b0};
               end
               bits_left_in = bits_left_ff - BW'(1);
               if (complete) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.out_byte = pend_bit;
                  rsp_in.last     = bits_left_ff <= BW'(8);
                  pend_in         = '0;
                  free_in         = 4'd8;
               end else begin
                  pend_in = pend_bit;
                  free_in = free_ff - 4'd1;
               end
               if (bits_left_ff == BW'(1)) begin
                  state_in = mbpg_pkg::ST_IDLE;
               end
            end
         end
         mbpg_pkg::ST_FLUSH: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.out_byte = pend_ff;
               rsp_in.last     = 1'b1;
               pend_in         = '0;
               free_in         = 4'd8;
               state_in        = mbpg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbpg_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbpg_pkg::ST_IDLE;
         pend_ff      <= '0;
         free_ff      <= 4'd8;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      sr_ff        <= sr_in;
      cnt_ff       <= cnt_in;
      data_len_ff  <= data_len_in;
      bits_left_ff <= bits_left_in;
      gamma_ff     <= gamma_in;
      rsp_ff       <= rsp_in;
   end

   // Free count always names a real bit position
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_ff != 4'd0 && free_ff <= 4'd8)
      else $error("free bit count out of range");

   // A gamma search finds its leading one before the length runs out
   a_gamma_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbpg_pkg::ST_ALIGN && gamma_ff) |-> cnt_ff != '0)
      else $error("gamma length underflow");

   // Packing never runs with no bits left
   a_emit_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == mbpg_pkg::ST_EMIT |-> bits_left_ff != '0)
      else $error("emit with no bits left");

   // A flush that emits leaves an empty partial byte
   a_flush_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbpg_pkg::ST_FLUSH && slot_free) |=>
         (free_ff == 4'd8 && pend_ff == 8'd0 && rsp_valid_ff && rsp_ff.last))
      else $error("flush did not clear pending byte");

endmodule

`default_nettype wire
